FILE: rtl/core/tlfd_pkg.sv
// Shared types and constants of the type-length frame deframer.
`default_nettype none
package tlfd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 24;

   // header bytes before the payload: one type byte, three length bytes
   localparam logic [2:0] HDR_BYTES = 3'd4;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'd4096;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } in_word_type;

   typedef struct packed {
      logic [LEN_W-1:0]  offset;
      logic              last;
      logic              has_data;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] kind;
   } rsp_word_type;

endpackage
`default_nettype wire

FILE: rtl/core/tlfd_in_stage.sv
// Input register of the deframer: holds one incoming stream word.
`default_nettype none
module tlfd_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,
   input  wire logic                take,
   output tlfd_pkg::in_word_type    in_word
);
   import tlfd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
      end
   end

   assign in_word.valid = valid_ff;
   assign in_word.data  = data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/tlfd_parse.sv
// Header/payload parser with the result register.
`default_nettype none
module tlfd_parse (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tlfd_pkg::in_word_type in_word,
   input  wire logic [23:0]           max_payload,
   output logic                       take,
   input  wire logic                  rsp_tready,
   output logic                       rsp_valid,
   output tlfd_pkg::rsp_word_type     rsp_word
);
   import tlfd_pkg::*;

   localparam logic [2:0] HC_KIND = 3'd0;
   localparam logic [2:0] HC_LEN0 = 3'd1;
   localparam logic [2:0] HC_LEN1 = 3'd2;
   localparam logic [2:0] HC_LEN2 = 3'd3;

   logic [2:0]        hc_ff, hc_in;
   logic [BYTE_W-1:0] kind_ff, kind_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pc_ff, pc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, res;

   logic              adv, emit, fin;
   logic [LEN_W-1:0]  full_len, off_inc;
   logic [BYTE_W-1:0] b;

   assign take = !rsp_valid_ff || rsp_tready;
   assign adv  = in_word.valid && take;
   assign b    = in_word.data;

   assign full_len = {b, len_ff[15:0]};
   assign off_inc  = pc_ff + 24'd1;
   assign fin      = (off_inc == len_ff) || (pc_ff >= len_ff);

   always_comb begin
      hc_in   = hc_ff;
      kind_in = kind_ff;
      len_in  = len_ff;
      pc_in   = pc_ff;
      emit    = 1'b0;
      res     = '0;
      if (hc_ff < HDR_BYTES) begin
         case (hc_ff)
            HC_KIND: begin
               kind_in = b;
               len_in  = '0;
            end
            HC_LEN0: len_in = {len_ff[23:8], b};
            HC_LEN1: len_in = {len_ff[23:16], b, len_ff[7:0]};
            HC_LEN2: len_in = full_len;
            default: ;
         endcase
         hc_in = hc_ff + 3'd1;
         if (hc_ff == HC_LEN2) begin
            pc_in = '0;
            if (full_len > max_payload) begin
               // oversized: drop header, resync on next byte
               hc_in = HC_KIND;
            end else if (full_len == '0) begin
               hc_in        = HC_KIND;
               emit         = 1'b1;
               res.kind     = kind_ff;
               res.length   = '0;
               res.last     = 1'b1;
            end
         end
      end else begin
         // payload (unused counter codes behave the same)
         emit         = 1'b1;
         res.kind     = kind_ff;
         res.length   = len_ff;
         res.data     = b;
         res.has_data = 1'b1;
         res.offset   = pc_ff;
         res.last     = fin;
         if (fin) begin
            hc_in = HC_KIND;
            pc_in = '0;
         end else begin
            pc_in = off_inc;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = adv && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= HC_KIND;
         kind_ff      <= '0;
         len_ff       <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            hc_ff   <= hc_in;
            kind_ff <= kind_in;
            len_ff  <= len_in;
            pc_ff   <= pc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_hc_range: assert property (@(posedge clock) disable iff (reset)
      hc_ff <= HDR_BYTES)
      else $error("header counter beyond payload code");

   a_notice_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.has_data |->
         rsp_ff.last && rsp_ff.offset == '0 && rsp_ff.data == '0 && rsp_ff.length == '0)
      else $error("zero-length notice with bad fields");

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_data |-> rsp_ff.offset < rsp_ff.length)
      else $error("payload offset not below frame length");

   a_last_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_data && rsp_ff.last |->
         rsp_ff.offset + 24'd1 == rsp_ff.length)
      else $error("last payload word at wrong offset");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/type_length_frame_deframer.sv
// Top level of the type-length frame deframer.
//
//  channel | dir | ports                      | contents
//  req     | in  | req_tvalid/tready/tdata    | tdata[7:0] in_byte
//  rsp     | out | rsp_tvalid/tready/tdata    | tdata: msg_kind, msg_length, data_byte,
//          |     | rsp_tlast, rsp_tuser       |   byte_offset; tlast last; tuser has_data
//  csr     | in  | csr_we, csr_wdata          | max_payload (24 bits)
//
// One word per cycle sustained while rsp_tready is high; a taken word reaches rsp through
// the input register, then the parser into the result register.
// req_tready follows rsp_tready through the result register's free test.
// Header words and dropped headers give no result, except that the last header word of an
// empty frame gives a notice; every payload word gives one.
// Synchronous reset clears the parser state and sets max_payload to 4096.
`default_nettype none
module type_length_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] msg_kind, [31:8] msg_length, [39:32] data_byte, [63:40] byte_offset
   output logic [63:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // [0] has_data
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata
);
   import tlfd_pkg::*;

   logic [LEN_W-1:0] max_ff, max_in;
   in_word_type      in_word;
   rsp_word_type     rsp_word;
   logic             take;

   assign max_in = csr_we ? csr_wdata : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_ff <= max_in;
      end
   end

   tlfd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .in_word    (in_word)
   );

   tlfd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .in_word     (in_word),
      .max_payload (max_ff),
      .take        (take),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = {rsp_word.offset, rsp_word.data, rsp_word.length, rsp_word.kind};
   assign rsp_tlast = rsp_word.last;
   assign rsp_tuser = rsp_word.has_data;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench of the type-length frame deframer: random framed byte streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tlfd_pkg::*;

   localparam int LIMIT     = 200000;
   localparam int HOLD_LONG = 400;
   localparam int PHASES    = 8;
   localparam logic [LEN_W-1:0] LEN_ALL = '1;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_type;
   typedef enum {GOOD_FRAME, BIG_HEADER, NOISE, SHORT_FRAME} shape_type;

   typedef struct {
      logic [BYTE_W-1:0] kind;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data;
      logic              has_data;
      logic [LEN_W-1:0]  offset;
      logic              last;
   } frame_word_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;
   logic              csr_we     = 1'b0;
   logic [LEN_W-1:0]  csr_wdata  = '0;

   logic [BYTE_W-1:0] pending_bytes[$];
   frame_word_type    expected_words[$];
   idle_type          idle_mode = IDLE_NONE;
   logic              req_fire  = 1'b0;
   bit                hold_ask  = 0;
   int                errors    = 0;
   int                cycle_count = 0;

   // parser state of the prediction
   logic [2:0]        hdr_count;
   logic [BYTE_W-1:0] frm_kind;
   logic [LEN_W-1:0]  frm_len;
   logic [LEN_W-1:0]  pay_count;
   logic [LEN_W-1:0]  max_len;

   type_length_frame_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report(input string msg);
      errors++;
      if (errors <= 30) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [LEN_W-1:0] got,
                              input logic [LEN_W-1:0] want);
      if (got !== want) begin
         report($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   // one byte through the parser; returns 1 when the byte yields a word
   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                       output frame_word_type res);
      logic [LEN_W-1:0] off;
      logic             fin;
      res = '{default: '0};
      if (hdr_count < HDR_BYTES) begin
         if (hdr_count == 3'd0) begin
            frm_kind = b;
            frm_len  = '0;
         end else begin
            frm_len = frm_len | (LEN_W'(b) << (8 * (hdr_count - 3'd1)));
         end
         hdr_count = hdr_count + 3'd1;
         if (hdr_count < HDR_BYTES) return 0;
         pay_count = '0;
         if (frm_len > max_len) begin
            hdr_count = '0;
            return 0;
         end
         if (frm_len == '0) begin
            hdr_count  = '0;
            res.kind   = frm_kind;
            res.length = frm_len;
            res.last   = 1'b1;
            return 1;
         end
         return 0;
      end
      off = pay_count;
      // a short frame ends where the wrapped count meets the length
      fin = (off + 1'b1 == frm_len) || (off >= frm_len);
      res.kind     = frm_kind;
      res.length   = frm_len;
      res.data     = b;
      res.has_data = 1'b1;
      res.offset   = off;
      res.last     = fin;
      pay_count = off + 1'b1;
      if (fin) begin
         hdr_count = '0;
         pay_count = '0;
      end
      return 1;
   endfunction

   function automatic bit send_gap();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(99) < 68;
         IDLE_BOTH: return $urandom_range(99) < 32;
         default:   return 0;
      endcase
   endfunction

   function automatic bit recv_stall();
      case (idle_mode)
         IDLE_RECV: return $urandom_range(99) < 68;
         IDLE_BOTH: return $urandom_range(99) < 32;
         default:   return 0;
      endcase
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_bytes.size() != 0 && !send_gap()) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_pacer
      int hold_left;
      if (hold_ask) begin
         hold_left = HOLD_LONG;
         hold_ask  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !recv_stall();
      end
   end

   always @(posedge clock) begin : scoreboard
      frame_word_type want;
      frame_word_type res;
      cycle_count++;
      if (reset) begin
         hdr_count = '0;
         frm_kind  = '0;
         frm_len   = '0;
         pay_count = '0;
         max_len   = MAX_PAYLOAD_RESET;
         req_fire <= 1'b0;
      end else begin
         if (csr_we) max_len = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               want = expected_words.pop_front();
               check_field("msg_kind", LEN_W'(rsp_tdata[7:0]), LEN_W'(want.kind));
               check_field("msg_length", rsp_tdata[31:8], want.length);
               check_field("data_byte", LEN_W'(rsp_tdata[39:32]), LEN_W'(want.data));
               check_field("byte_offset", rsp_tdata[63:40], want.offset);
               check_field("has_data", LEN_W'(rsp_tuser), LEN_W'(want.has_data));
               check_field("last", LEN_W'(rsp_tlast), LEN_W'(want.last));
            end
         end
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready && deframe_byte(req_tdata, res)) begin
            expected_words.push_back(res);
         end
      end
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_words.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   task automatic push_header(input logic [BYTE_W-1:0] kind, input logic [LEN_W-1:0] len);
      pending_bytes.push_back(kind);
      pending_bytes.push_back(len[7:0]);
      pending_bytes.push_back(len[15:8]);
      pending_bytes.push_back(len[23:16]);
   endtask

   task automatic write_max(input logic [LEN_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      @(posedge clock);
   endtask

   // everything sent and answered, then a wait for dropped headers in flight
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // mostly well-formed frames; bad headers, noise and short frames where they cannot
   // start a huge payload
   task automatic gen_phase(input int n, input logic [LEN_W-1:0] lim);
      int        sent;
      int        pick;
      int        len;
      int        cap;
      int        k;
      shape_type shape;
      sent = 0;
      while (sent < n) begin
         pick  = $urandom_range(99);
         cap   = (lim < 16) ? int'(lim) : 16;
         shape = (pick < 65) ? GOOD_FRAME : (pick < 82) ? BIG_HEADER :
                 (pick < 91) ? NOISE : SHORT_FRAME;
         if (shape == BIG_HEADER && lim == LEN_ALL) shape = GOOD_FRAME;
         if ((shape == NOISE || shape == SHORT_FRAME) && lim > 4096) shape = GOOD_FRAME;
         if (shape == SHORT_FRAME && cap < 2) shape = GOOD_FRAME;
         case (shape)
            GOOD_FRAME: begin
               case ($urandom_range(3))
                  0:       len = 0;
                  1:       len = (lim <= 64) ? int'(lim) : $urandom_range(64, 1);
                  default: len = (cap == 0) ? 0 : $urandom_range(cap, 1);
               endcase
               push_header(rand_byte(), LEN_W'(len));
               for (k = 0; k < len; k++) pending_bytes.push_back(rand_byte());
               sent += 4 + len;
            end
            BIG_HEADER: begin
               len = ($urandom_range(1) == 0) ? int'(lim) + 1 :
                     $urandom_range(int'(LEN_ALL), int'(lim) + 1);
               push_header(rand_byte(), LEN_W'(len));
               sent += 4;
            end
            NOISE: begin
               len = $urandom_range(6, 1);
               for (k = 0; k < len; k++) pending_bytes.push_back(BYTE_W'($urandom_range(255)));
               sent += len;
            end
            default: begin
               len = $urandom_range(cap, 2);
               push_header(rand_byte(), LEN_W'(len));
               k = $urandom_range(len - 1, 1);
               sent += 4 + k;
               while (k > 0) begin
                  pending_bytes.push_back(rand_byte());
                  k--;
               end
            end
         endcase
      end
   endtask

   initial begin : stimulus
      logic [LEN_W-1:0] max_plan[PHASES];
      int               p;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // reset value of the limit: one header past it, a notice, extreme bytes
      push_header(8'hFF, 24'd4097);
      push_header(8'h00, 24'd0);
      push_header(8'hA5, 24'd2);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      wait_drained();

      // one past the limit, then a frame left open across a limit change
      write_max(24'd2);
      push_header(8'h3C, 24'd3);
      push_header(8'hC3, 24'd2);
      pending_bytes.push_back(8'h5A);
      wait_drained();

      max_plan[0] = '0;
      max_plan[1] = LEN_ALL;
      max_plan[2] = 24'd1;
      max_plan[3] = LEN_W'($urandom_range(64, 2));
      max_plan[4] = 24'd4096;
      max_plan[5] = LEN_W'($urandom_range(4096, 65));
      max_plan[6] = LEN_ALL;
      max_plan[7] = 24'd3;
      for (p = 0; p < PHASES; p++) begin
         write_max(max_plan[p]);
         idle_mode = idle_type'(p % 4);
         if (p == 4) hold_ask = 1;
         gen_phase(165, max_plan[p]);
         wait_drained();
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
